// File: rtl/dtn_pkg.sv
package dtn_pkg;

  // field widths
  localparam int unsigned MilliInW  = 12;
  localparam int unsigned SecInW    = 8;
  localparam int unsigned MinInW    = 8;
  localparam int unsigned HourInW   = 7;
  localparam int unsigned DayInW    = 6;
  localparam int unsigned MonthW    = 4;
  localparam int unsigned YearW     = 14;
  localparam int unsigned MilliOutW = 10;
  localparam int unsigned SecOutW   = 6;
  localparam int unsigned MinOutW   = 6;
  localparam int unsigned HourOutW  = 5;
  localparam int unsigned DayOutW   = 5;

  // carry divisors
  localparam logic signed [12:0] MS_PER_SEC    = 13'sd1000;
  localparam logic signed [12:0] SEC_PER_MIN   = 13'sd60;
  localparam logic signed [12:0] MIN_PER_HOUR  = 13'sd60;
  localparam logic signed [12:0] HOURS_PER_DAY = 13'sd24;

  // year / 25 by reciprocal, exact for every 14-bit year
  localparam logic [12:0] Y25_RECIP = 13'd5243;
  localparam int unsigned Y25_SHIFT = 17;
  localparam logic [4:0]  Y25_DIV   = 5'd25;

  // month codes
  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_APR = 4'd4;
  localparam logic [3:0] MONTH_JUN = 4'd6;
  localparam logic [3:0] MONTH_SEP = 4'd9;
  localparam logic [3:0] MONTH_NOV = 4'd11;
  localparam logic [3:0] MONTH_DEC = 4'd12;

  // month lengths
  localparam logic [4:0] DAYS_LONG  = 5'd31;
  localparam logic [4:0] DAYS_SHORT = 5'd30;
  localparam logic [4:0] DAYS_LEAP  = 5'd29;
  localparam logic [4:0] DAYS_FEB   = 5'd28;

  typedef struct packed {
    logic signed [2:0] q;
    logic [9:0]        r;
  } carry_t;

  // day after carries, month and year going into the calendar fix
  typedef struct packed {
    logic signed [7:0] day;
    logic [3:0]        month;
    logic [13:0]       year;
    logic              leap;
  } cal_in_t;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } cal_out_t;

  // floor division of a small value by a constant, quotient within -3..2
  function automatic carry_t carry_div(input logic signed [12:0] v,
                                       input logic signed [12:0] dv);
    logic signed [14:0] vv;
    logic signed [14:0] dd;
    logic signed [14:0] rr;
    logic [2:0]         cnt;
    carry_t             c;
    vv  = 15'(v);
    dd  = 15'(dv);
    cnt = 3'(vv >= -(dd + dd)) + 3'(vv >= -dd) + 3'(vv >= 15'sd0)
        + 3'(vv >= dd) + 3'(vv >= (dd + dd));
    case (cnt)
      3'd0:    rr = vv + dd + dd + dd;
      3'd1:    rr = vv + dd + dd;
      3'd2:    rr = vv + dd;
      3'd3:    rr = vv;
      3'd4:    rr = vv - dd;
      default: rr = vv - dd - dd;
    endcase
    c.q = 3'(cnt - 3'd3);
    c.r = rr[9:0];
    return c;
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] mo, input logic leap);
    logic [4:0] n;
    case (mo) inside
      MONTH_FEB:                                  n = leap ? DAYS_LEAP : DAYS_FEB;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: n = DAYS_SHORT;
      default:                                    n = DAYS_LONG;
    endcase
    return n;
  endfunction

endpackage

// File: rtl/dtn_in_if.sv
interface dtn_in_if;
  import dtn_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [MilliInW-1:0] milli_in;
  logic signed [SecInW-1:0]   sec_in;
  logic signed [MinInW-1:0]   min_in;
  logic signed [HourInW-1:0]  hour_in;
  logic [DayInW-1:0]          day_in;
  logic [MonthW-1:0]          month_in;
  logic [YearW-1:0]           year_in;

  modport source (output valid, milli_in, sec_in, min_in, hour_in, day_in, month_in,
                  year_in, input ready);
  modport sink (input valid, milli_in, sec_in, min_in, hour_in, day_in, month_in,
                year_in, output ready);
endinterface

// File: rtl/dtn_out_if.sv
interface dtn_out_if;
  import dtn_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MilliOutW-1:0] milli_out;
  logic [SecOutW-1:0]   sec_out;
  logic [MinOutW-1:0]   min_out;
  logic [HourOutW-1:0]  hour_out;
  logic [DayOutW-1:0]   day_out;
  logic [MonthW-1:0]    month_out;
  logic [YearW-1:0]     year_out;

  modport source (output valid, milli_out, sec_out, min_out, hour_out, day_out,
                  month_out, year_out, input ready);
  modport sink (input valid, milli_out, sec_out, min_out, hour_out, day_out,
                month_out, year_out, output ready);
endinterface

// File: rtl/datetime_normalizer_core.sv
// Normalizes one Gregorian date and time per word after a signed shift of up to
// about a day: milliseconds, seconds, minutes and hours carry or borrow upward by
// floor division, then the day is folded into the previous or next month with the
// full leap-year rule, wrapping the year at December and January (modulo 2^14).
// A month of 0 reads as January and one above 12 as December. The datapath is five
// register stages (milliseconds, seconds and leap test, minutes, hours, month
// fix), and a new word is taken every cycle while the output is not stalled; each
// stage holds only while the stage after it is full and stalled, so bubbles are
// squeezed out under back-pressure.
module datetime_normalizer_core (
  input logic  clk,
  input logic  rst,
  dtn_in_if.sink    din,
  dtn_out_if.source dout
);
  import dtn_pkg::*;

  // stage valids and advance enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  assign en5 = !dout.valid || dout.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign din.ready = en1;

  // stage 1: milliseconds, month clamp, year/25 product
  carry_t            c1;
  logic signed [2:0] q1;
  logic [3:0]        month_clamp;
  logic [26:0]       y25_prod;

  logic [9:0]         ms1;
  logic signed [8:0]  sec1;
  logic signed [7:0]  min1;
  logic signed [6:0]  hour1;
  logic [5:0]         day1;
  logic [3:0]         month1;
  logic [13:0]        year1;
  logic [9:0]         y25q1;

  assign c1       = carry_div(13'(din.milli_in), MS_PER_SEC);
  assign q1       = c1.q;
  assign y25_prod = 27'(din.year_in) * 27'(Y25_RECIP);

  always_comb begin
    if (din.month_in < MONTH_JAN) begin
      month_clamp = MONTH_JAN;
    end else if (din.month_in > MONTH_DEC) begin
      month_clamp = MONTH_DEC;
    end else begin
      month_clamp = din.month_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && din.valid) begin
      ms1    <= c1.r;
      sec1   <= 9'(din.sec_in) + 9'(q1);
      min1   <= din.min_in;
      hour1  <= din.hour_in;
      day1   <= din.day_in;
      month1 <= month_clamp;
      year1  <= din.year_in;
      y25q1  <= y25_prod[Y25_SHIFT +: 10];
    end
  end

  // stage 2: seconds, leap test
  carry_t            c2;
  logic signed [2:0] q2;
  logic              div4;
  logic              div16;
  logic              div25;
  logic              leap_next;

  logic [9:0]        ms2;
  logic [5:0]        sec2;
  logic signed [8:0] min2;
  logic signed [6:0] hour2;
  logic [5:0]        day2;
  logic [3:0]        month2;
  logic [13:0]       year2;
  logic              leap2;

  assign c2        = carry_div(13'(sec1), SEC_PER_MIN);
  assign q2        = c2.q;
  assign div4      = (year1[1:0] == 2'd0);
  assign div16     = (year1[3:0] == 4'd0);
  assign div25     = ((15'(y25q1) * 15'(Y25_DIV)) == 15'(year1));
  assign leap_next = div4 && (!div25 || div16);

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      ms2    <= ms1;
      sec2   <= c2.r[5:0];
      min2   <= 9'(min1) + 9'(q2);
      hour2  <= hour1;
      day2   <= day1;
      month2 <= month1;
      year2  <= year1;
      leap2  <= leap_next;
    end
  end

  // stage 3: minutes
  carry_t            c3;
  logic signed [2:0] q3;

  logic [9:0]        ms3;
  logic [5:0]        sec3;
  logic [5:0]        min3;
  logic signed [7:0] hour3;
  logic [5:0]        day3;
  logic [3:0]        month3;
  logic [13:0]       year3;
  logic              leap3;

  assign c3 = carry_div(13'(min2), MIN_PER_HOUR);
  assign q3 = c3.q;

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      ms3    <= ms2;
      sec3   <= sec2;
      min3   <= c3.r[5:0];
      hour3  <= 8'(hour2) + 8'(q3);
      day3   <= day2;
      month3 <= month2;
      year3  <= year2;
      leap3  <= leap2;
    end
  end

  // stage 4: hours into the day
  carry_t            c4;
  logic signed [2:0] q4;

  logic [9:0]        ms4;
  logic [5:0]        sec4;
  logic [5:0]        min4;
  logic [4:0]        hour4;
  cal_in_t           cal4;

  assign c4 = carry_div(13'(hour3), HOURS_PER_DAY);
  assign q4 = c4.q;

  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      ms4        <= ms3;
      sec4       <= sec3;
      min4       <= min3;
      hour4      <= c4.r[4:0];
      cal4.day   <= $signed({2'b00, day3}) + 8'(q4);
      cal4.month <= month3;
      cal4.year  <= year3;
      cal4.leap  <= leap3;
    end
  end

  // stage 5: month fix into the output register
  cal_out_t cal5;

  dtn_month_fix u_month_fix (
    .cal_in  (cal4),
    .cal_out (cal5)
  );

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      dout.milli_out <= ms4;
      dout.sec_out   <= sec4;
      dout.min_out   <= min4;
      dout.hour_out  <= hour4;
      dout.day_out   <= cal5.day;
      dout.month_out <= cal5.month;
      dout.year_out  <= cal5.year;
    end
  end

  // valid bits travel with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      v4         <= 1'b0;
      dout.valid <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= din.valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        v4 <= v3;
      end
      if (en5) begin
        dout.valid <= v4;
      end
    end
  end

`ifndef SYNTHESIS
  // a held word in the first stage is never dropped
  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    v1 && !en2 |=> v1)
    else $error("stage 1 word lost while stalled");

  // time fields leave in range
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> dout.milli_out < 10'd1000 && dout.sec_out < 6'd60
                   && dout.min_out < 6'd60 && dout.hour_out < 5'd24)
    else $error("time field out of range");

  // date fields leave in range
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    dout.valid |-> dout.day_out >= 5'd1 && dout.month_out >= MONTH_JAN
                   && dout.month_out <= MONTH_DEC)
    else $error("date field out of range");

  // a word taken at the input reaches stage 1
  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    din.valid && din.ready |=> v1)
    else $error("accepted word missing from stage 1");
`endif

endmodule

// File: rtl/dtn_month_fix.sv
module dtn_month_fix (
  input  dtn_pkg::cal_in_t  cal_in,
  output dtn_pkg::cal_out_t cal_out
);
  import dtn_pkg::*;

  logic [4:0] dim_cur;
  logic [4:0] dim_prev;
  logic [3:0] prev_month;
  logic [3:0] next_month;
  logic [13:0] prev_year;
  logic [13:0] next_year;

  // neighbor months with year wrap at december and january
  always_comb begin
    if (cal_in.month == MONTH_JAN) begin
      prev_month = MONTH_DEC;
      prev_year  = cal_in.year - 14'd1;
    end else begin
      prev_month = cal_in.month - 4'd1;
      prev_year  = cal_in.year;
    end
    if (cal_in.month == MONTH_DEC) begin
      next_month = MONTH_JAN;
      next_year  = cal_in.year + 14'd1;
    end else begin
      next_month = cal_in.month + 4'd1;
      next_year  = cal_in.year;
    end
  end

  // leap flag only matters for february, which never crosses a year here
  assign dim_cur  = days_in(cal_in.month, cal_in.leap);
  assign dim_prev = days_in(prev_month, cal_in.leap);

  // pull the day back into its month
  always_comb begin
    if (cal_in.day < 8'sd1) begin
      cal_out.day   = dim_prev;
      cal_out.month = prev_month;
      cal_out.year  = prev_year;
    end else if (cal_in.day > $signed({3'b000, dim_cur})) begin
      cal_out.day   = 5'd1;
      cal_out.month = next_month;
      cal_out.year  = next_year;
    end else begin
      cal_out.day   = cal_in.day[4:0];
      cal_out.month = cal_in.month;
      cal_out.year  = cal_in.year;
    end
  end

endmodule

// File: sim/datetime_normalizer_core_test.sv
module datetime_normalizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dtn_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 10;
  localparam int REPORT_LIMIT   = 10;
  localparam int PHASE_WORDS    = 170;
  localparam int unsigned YEAR_MASK = (1 << YearW) - 1;

  // one datetime going in, fields as they sit on the bus
  typedef struct {
    logic signed [MilliInW-1:0] milli;
    logic signed [SecInW-1:0]   sec;
    logic signed [MinInW-1:0]   min;
    logic signed [HourInW-1:0]  hour;
    logic [DayInW-1:0]          day;
    logic [MonthW-1:0]          month;
    logic [YearW-1:0]           year;
  } dt_word_t;

  // one normalized datetime coming out
  typedef struct packed {
    logic [MilliOutW-1:0] milli;
    logic [SecOutW-1:0]   sec;
    logic [MinOutW-1:0]   min;
    logic [HourOutW-1:0]  hour;
    logic [DayOutW-1:0]   day;
    logic [MonthW-1:0]    month;
    logic [YearW-1:0]     year;
  } dt_result_t;

  logic clk;
  logic rst;

  dtn_in_if  in_ch ();
  dtn_out_if out_ch ();

  datetime_normalizer_core dut (
    .clk  (clk),
    .rst  (rst),
    .din  (in_ch),
    .dout (out_ch)
  );

  dt_result_t normalized_q[$];

  int send_idle_pct;
  int stall_pct;
  int hold_requests;
  int words_sent;
  int results_checked;
  int bad_count;
  int input_stalls;
  int hold_offs;
  int idle_cycles;

  // clock, 4 ns period
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // floor division with non-negative remainder left in v
  function automatic int carry_floor(inout int v, input int dv);
    int q;
    q = v / dv;
    v = v % dv;
    if (v < 0) begin
      v += dv;
      q -= 1;
    end
    return q;
  endfunction

  function automatic bit gregorian_leap(int unsigned y);
    if (y % 4 != 0) return 1'b0;
    if (y % 100 != 0) return 1'b1;
    return (y % 400) == 0;
  endfunction

  function automatic int month_length(int unsigned m, int unsigned y);
    if (m == MONTH_FEB) return gregorian_leap(y) ? int'(DAYS_LEAP) : int'(DAYS_FEB);
    if (m == MONTH_APR || m == MONTH_JUN || m == MONTH_SEP || m == MONTH_NOV)
      return int'(DAYS_SHORT);
    return int'(DAYS_LONG);
  endfunction

  // expected normalized datetime for one word
  function automatic dt_result_t normalize_datetime(dt_word_t w);
    dt_result_t r;
    int ms;
    int s;
    int mi;
    int h;
    int d;
    int unsigned mo;
    int unsigned y;
    ms = w.milli;
    s  = w.sec;
    mi = w.min;
    h  = w.hour;
    d  = int'(w.day);
    mo = w.month;
    y  = w.year;
    if (mo < MONTH_JAN) mo = MONTH_JAN;
    if (mo > MONTH_DEC) mo = MONTH_DEC;

    // ripple carries and borrows upward
    s  += carry_floor(ms, int'(MS_PER_SEC));
    mi += carry_floor(s, int'(SEC_PER_MIN));
    h  += carry_floor(mi, int'(MIN_PER_HOUR));
    d  += carry_floor(h, int'(HOURS_PER_DAY));

    // fold the day into the previous or next month
    if (d < 1) begin
      if (mo == MONTH_JAN) begin
        mo = MONTH_DEC;
        y  = (y - 1) & YEAR_MASK;
      end else begin
        mo -= 1;
      end
      d = month_length(mo, y);
    end else if (d > month_length(mo, y)) begin
      d = 1;
      if (mo == MONTH_DEC) begin
        mo = MONTH_JAN;
        y  = (y + 1) & YEAR_MASK;
      end else begin
        mo += 1;
      end
    end

    r.milli = MilliOutW'(ms);
    r.sec   = SecOutW'(s);
    r.min   = MinOutW'(mi);
    r.hour  = HourOutW'(h);
    r.day   = DayOutW'(d);
    r.month = MonthW'(mo);
    r.year  = YearW'(y);
    return r;
  endfunction

  // value at a carry edge: just below zero, zero, just below and at the divisor
  function automatic int near_carry(int dv);
    case ($urandom_range(3))
      0:       return -1;
      1:       return 0;
      2:       return dv - 1;
      default: return dv;
    endcase
  endfunction

  function automatic dt_word_t pick_datetime();
    dt_word_t w;
    int unsigned kind;
    kind = $urandom_range(99);
    if (kind < 25) begin
      // raw bits over the full width of every field
      w.milli = MilliInW'($urandom);
      w.sec   = SecInW'($urandom);
      w.min   = MinInW'($urandom);
      w.hour  = HourInW'($urandom);
      w.day   = DayInW'($urandom);
      w.month = MonthW'($urandom);
      w.year  = YearW'($urandom);
    end else begin
      if (kind < 50) begin
        // sit on the borrow and carry edges
        w.milli = MilliInW'(near_carry(1000));
        w.sec   = SecInW'(near_carry(60));
        w.min   = MinInW'(near_carry(60));
        w.hour  = HourInW'(near_carry(24));
      end else begin
        w.milli = MilliInW'(int'($urandom_range(2999)) - 1000);
        w.sec   = SecInW'(int'($urandom_range(179)) - 60);
        w.min   = MinInW'(int'($urandom_range(179)) - 60);
        w.hour  = HourInW'(int'($urandom_range(71)) - 24);
      end
      // day near month ends half of the time
      if ($urandom_range(1) == 0) begin
        case ($urandom_range(6))
          0:       w.day = DayInW'(0);
          1:       w.day = DayInW'(1);
          2:       w.day = DayInW'(28);
          3:       w.day = DayInW'(29);
          4:       w.day = DayInW'(30);
          5:       w.day = DayInW'(31);
          default: w.day = DayInW'(32);
        endcase
      end else begin
        w.day = DayInW'($urandom_range(32));
      end
      w.month = MonthW'($urandom_range(12, 1));
      // years that stress the leap rule
      case ($urandom_range(7))
        0:       w.year = YearW'(1);
        1:       w.year = YearW'(9998);
        2:       w.year = YearW'(400 * $urandom_range(24, 1));
        3:       w.year = YearW'(100 * $urandom_range(99, 1));
        4:       w.year = YearW'(4 * $urandom_range(2499, 1));
        default: w.year = YearW'($urandom_range(9998, 1));
      endcase
    end
    return w;
  endfunction

  // offer one word, entered and left at a falling edge
  task automatic send_word(dt_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.milli_in <= w.milli;
    in_ch.sec_in   <= w.sec;
    in_ch.min_in   <= w.min;
    in_ch.hour_in  <= w.hour;
    in_ch.day_in   <= w.day;
    in_ch.month_in <= w.month;
    in_ch.year_in  <= w.year;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drive_datetime(int ms, int s, int mi, int h, int d, int mo, int y);
    dt_word_t w;
    w.milli = MilliInW'(ms);
    w.sec   = SecInW'(s);
    w.min   = MinInW'(mi);
    w.hour  = HourInW'(h);
    w.day   = DayInW'(d);
    w.month = MonthW'(mo);
    w.year  = YearW'(y);
    send_word(w);
  endtask

  task automatic test_calendar_corners();
    send_idle_pct = 0;
    stall_pct     = 0;
    // field extremes within the stated ranges
    drive_datetime(0, 0, 0, 0, 1, 1, 1);
    drive_datetime(1999, 119, 119, 47, 31, 12, 9998);
    drive_datetime(-1000, -60, -60, -24, 0, 1, 1);
    // day below one across leap rules
    drive_datetime(0, 0, 0, 0, 0, 3, 2000);
    drive_datetime(0, 0, 0, 0, 0, 3, 1900);
    drive_datetime(0, 0, 0, 0, 0, 3, 2024);
    drive_datetime(0, 0, 0, 0, 0, 3, 2023);
    drive_datetime(-1, 0, 0, 0, 1, 3, 2100);
    // day past month end, then the last millisecond of a year
    drive_datetime(0, 0, 0, 0, 29, 2, 1900);
    drive_datetime(0, 0, 0, 0, 30, 2, 2000);
    drive_datetime(0, 0, 0, 0, 31, 4, 2001);
    drive_datetime(0, 0, 0, 0, 32, 12, 9998);
    drive_datetime(999, 59, 59, 23, 31, 12, 1999);
    // year wraps at both ends of the 14-bit range
    drive_datetime(0, 0, 0, 0, 0, 1, 0);
    drive_datetime(0, 0, 0, 0, 32, 12, 16383);
    // month codes outside 1..12
    drive_datetime(0, 0, 0, 0, 0, 0, 2000);
    drive_datetime(0, 0, 0, 0, 32, 13, 2000);
    drive_datetime(0, 0, 0, 0, 15, 15, 2000);
    // full-width inputs, far below and far past the month
    drive_datetime(-2048, -128, -128, -64, 0, 5, 5000);
    drive_datetime(2047, 127, 127, 63, 63, 5, 5000);
    drive_datetime(0, 0, 0, -64, 2, 8, 300);
  endtask

  task automatic run_random_words(int n);
    repeat (n) send_word(pick_datetime());
  endtask

  task automatic test_streaming();
    send_idle_pct = 0;
    stall_pct     = 0;
    run_random_words(PHASE_WORDS);
  endtask

  task automatic test_sparse_sender();
    send_idle_pct = 75;
    stall_pct     = 0;
    run_random_words(PHASE_WORDS);
  endtask

  task automatic test_slow_receiver();
    send_idle_pct = 0;
    stall_pct     = 75;
    run_random_words(PHASE_WORDS);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 28;
    stall_pct     = 28;
    run_random_words(PHASE_WORDS);
  endtask

  // receiver holds off long enough for the pipeline to fill and stall its input
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests++;
    run_random_words(40);
  endtask

  // receiver side: random stalls plus an occasional long hold-off
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_left = HOLD_CYCLES;
        hold_seen = hold_requests;
        hold_offs++;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // predict each accepted word
  always @(posedge clk) begin : input_monitor
    dt_word_t w;
    if (!rst && in_ch.valid) begin
      if (in_ch.ready) begin
        w.milli = in_ch.milli_in;
        w.sec   = in_ch.sec_in;
        w.min   = in_ch.min_in;
        w.hour  = in_ch.hour_in;
        w.day   = in_ch.day_in;
        w.month = in_ch.month_in;
        w.year  = in_ch.year_in;
        normalized_q.push_back(normalize_datetime(w));
        words_sent++;
      end else begin
        input_stalls++;
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_checker
    dt_result_t got;
    dt_result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.milli = out_ch.milli_out;
      got.sec   = out_ch.sec_out;
      got.min   = out_ch.min_out;
      got.hour  = out_ch.hour_out;
      got.day   = out_ch.day_out;
      got.month = out_ch.month_out;
      got.year  = out_ch.year_out;
      if (normalized_q.size() == 0) begin
        bad_count++;
        if (bad_count <= REPORT_LIMIT)
          $display("unexpected word %0d-%0d-%0d %0d:%0d:%0d.%0d",
                   got.year, got.month, got.day, got.hour, got.min, got.sec, got.milli);
      end else begin
        want = normalized_q.pop_front();
        results_checked++;
        if (got != want) begin
          bad_count++;
          if (bad_count <= REPORT_LIMIT) begin
            $display("word %0d: expected %0d-%0d-%0d %0d:%0d:%0d.%0d",
                     results_checked,
                     want.year, want.month, want.day, want.hour, want.min, want.sec,
                     want.milli);
            $display("  got %0d-%0d-%0d %0d:%0d:%0d.%0d",
                     got.year, got.month, got.day, got.hour, got.min, got.sec, got.milli);
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles, %0d results outstanding",
                 idle_cycles, normalized_q.size());
        $display("datetime_normalizer_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst            = 1'b1;
    hold_requests  = 0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    in_ch.valid    = 1'b0;
    in_ch.milli_in = '0;
    in_ch.sec_in   = '0;
    in_ch.min_in   = '0;
    in_ch.hour_in  = '0;
    in_ch.day_in   = '0;
    in_ch.month_in = '0;
    in_ch.year_in  = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_calendar_corners();
    test_streaming();
    test_sparse_sender();
    test_slow_receiver();
    test_both_idle();
    test_output_hold_off();

    // drain the pipeline
    in_ch.valid <= 1'b0;
    stall_pct = 0;
    while (normalized_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d words normalized, %0d results checked, %0d mismatches",
             words_sent, results_checked, bad_count);
    $display("four idle mixes, %0d long output hold-off(s), %0d input stall cycles",
             hold_offs, input_stalls);
    if (bad_count == 0 && normalized_q.size() == 0) begin
      $display("datetime_normalizer_core: match");
    end else begin
      $display("datetime_normalizer_core: mismatch");
    end
    $finish;
  end

endmodule
